// ===== src/dual_gated_ema_with_timeout_assert.svh =====
// Assertion macros used by the RTL of the dual gated average block.
// Each macro checks one implication at the rising clock edge, with reset
// holding the check off.
`ifndef DUAL_GATED_EMA_WITH_TIMEOUT_ASSERT_SVH
`define DUAL_GATED_EMA_WITH_TIMEOUT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define DGEMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DGEMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define DGEMA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DGEMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/dgema_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dgema_pkg;

  // Fixed field widths.
  localparam int SAMPLE_FRAC_BITS = 4;
  localparam int OUT_WIDTH        = 9;
  localparam int CFG_WIDTH        = 16;
  localparam int ALPHA_WIDTH      = 9;
  localparam int TIME_WIDTH       = 32;

  // Register reset values.
  localparam logic signed [CFG_WIDTH-1:0] PLAUSIBLE_MIN_RST = -16'sd640;
  localparam logic signed [CFG_WIDTH-1:0] PLAUSIBLE_MAX_RST = 16'sd3200;
  localparam logic [ALPHA_WIDTH-1:0]      ALPHA_Q8_RST      = 9'd51;
  localparam logic [CFG_WIDTH-1:0]        STALE_TIMEOUT_RST = 16'd500;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_PLAUSIBLE_MIN    = 2'd0,
    CFG_PLAUSIBLE_MAX    = 2'd1,
    CFG_ALPHA_Q8         = 2'd2,
    CFG_STALE_TIMEOUT_MS = 2'd3
  } cfg_index_t;

  // Configuration register set.
  typedef struct packed {
    logic signed [CFG_WIDTH-1:0] plausible_min;
    logic signed [CFG_WIDTH-1:0] plausible_max;
    logic [ALPHA_WIDTH-1:0]      alpha_q8;
    logic [CFG_WIDTH-1:0]        stale_timeout_ms;
  } cfg_t;

  // Per-channel status handed to the top level.
  typedef struct packed {
    logic                        fresh;
    logic signed [OUT_WIDTH-1:0] temp_c;
  } chan_res_t;

endpackage

`default_nettype wire

// ===== src/dgema_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: two samples and a timestamp per transaction.
interface dgema_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  import dgema_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_left;
  logic signed [SAMPLE_WIDTH-1:0] sample_right;
  logic [TIME_WIDTH-1:0]          now_ms;

  modport source (output valid, output sample_left, output sample_right, output now_ms,
                  input ready);
  modport sink   (input valid, input sample_left, input sample_right, input now_ms,
                  output ready);
endinterface

// Result channel: freshness flag and two rounded temperatures.
interface dgema_out_if;
  import dgema_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic signed [OUT_WIDTH-1:0] temp_left_c;
  logic signed [OUT_WIDTH-1:0] temp_right_c;

  modport source (output valid, output ok, output temp_left_c, output temp_right_c,
                  input ready);
  modport sink   (input valid, input ok, input temp_left_c, input temp_right_c,
                  output ready);
endinterface

`default_nettype wire

// ===== src/dgema_chan.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One temperature channel: plausibility gate, average update, last good
// time, age check and rounding to whole degrees.
module dgema_chan #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int FILTER_FRAC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                upd_en,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  wire logic [dgema_pkg::TIME_WIDTH-1:0]    now_ms,
  input  wire dgema_pkg::cfg_t                     cfg,
  output dgema_pkg::chan_res_t                     res
);
  import dgema_pkg::*;

  localparam int FW     = SAMPLE_WIDTH + FILTER_FRAC_BITS - SAMPLE_FRAC_BITS;
  localparam int Shift  = FILTER_FRAC_BITS - SAMPLE_FRAC_BITS;
  localparam int DW     = FW + 1;
  localparam int PW     = DW + ALPHA_WIDTH + 1;
  localparam int DLW    = PW - 8;
  localparam int SUMW   = FW + 4;
  localparam int CMPW   = (SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH;
  localparam int RMW    = FW + 1 - FILTER_FRAC_BITS;
  localparam logic signed [FW-1:0] FiltMax = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FiltMin = {1'b1, {(FW-1){1'b0}}};
  localparam logic [FW:0]          Half    = (FW+1)'(1) << (FILTER_FRAC_BITS - 1);
  localparam logic [RMW-1:0]       PosLim  = RMW'((1 << (OUT_WIDTH - 1)) - 1);
  localparam logic [RMW-1:0]       NegLim  = RMW'(1 << (OUT_WIDTH - 1));

  logic signed [FW-1:0]         filt_r, filt_nxt;
  logic [TIME_WIDTH-1:0]        last_good_r, last_good_nxt;

  logic                         plaus;
  logic signed [FW-1:0]         target;
  logic signed [DW-1:0]         diff;
  logic signed [ALPHA_WIDTH:0]  alpha_s;
  logic signed [PW-1:0]         prod;
  logic signed [DLW-1:0]        delta;
  logic signed [SUMW-1:0]       sum;
  logic signed [FW-1:0]         filt_new;
  logic signed [FW-1:0]         filt_cur;
  logic [TIME_WIDTH-1:0]        last_cur;
  logic [TIME_WIDTH-1:0]        age;
  logic [FW-1:0]                mag;
  logic [FW:0]                  rnd;
  logic [RMW-1:0]               rmag;
  logic signed [OUT_WIDTH-1:0]  temp;

  // Plausibility window check.
  assign plaus = (CMPW'(sample) >= CMPW'(cfg.plausible_min)) &&
                 (CMPW'(sample) <= CMPW'(cfg.plausible_max));

  // Average update: filt += floor(alpha * (target - filt) / 256), saturated.
  always_comb begin
    target  = FW'(sample) <<< Shift;
    diff    = DW'(target) - DW'(filt_r);
    alpha_s = $signed({1'b0, cfg.alpha_q8});
    prod    = PW'(alpha_s) * PW'(diff);
    delta   = DLW'(prod >>> 8);
    sum     = SUMW'(filt_r) + SUMW'(delta);
    if (sum > SUMW'(FiltMax)) begin
      filt_new = FiltMax;
    end else if (sum < SUMW'(FiltMin)) begin
      filt_new = FiltMin;
    end else begin
      filt_new = FW'(sum);
    end
  end

  // Values this transaction leaves behind.
  assign filt_cur      = plaus ? filt_new : filt_r;
  assign last_cur      = plaus ? now_ms : last_good_r;
  assign filt_nxt      = upd_en ? filt_cur : filt_r;
  assign last_good_nxt = upd_en ? last_cur : last_good_r;

  // Wrapping age against the timeout.
  assign age = now_ms - last_cur;

  // Round half away from zero to whole degrees, then saturate.
  always_comb begin
    mag  = filt_cur[FW-1] ? (~filt_cur + FW'(1)) : filt_cur;
    rnd  = {1'b0, mag} + Half;
    rmag = rnd[FW:FILTER_FRAC_BITS];
    if (filt_cur[FW-1]) begin
      if (rmag > NegLim) begin
        temp = -OUT_WIDTH'(NegLim);
      end else begin
        temp = -OUT_WIDTH'(rmag);
      end
    end else begin
      if (rmag > PosLim) begin
        temp = OUT_WIDTH'(PosLim);
      end else begin
        temp = OUT_WIDTH'(rmag);
      end
    end
  end

  assign res.fresh  = (age <= TIME_WIDTH'(cfg.stale_timeout_ms));
  assign res.temp_c = temp;

  // Channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r      <= '0;
      last_good_r <= '0;
    end else begin
      filt_r      <= filt_nxt;
      last_good_r <= last_good_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_gated_ema_with_timeout.sv =====
// Dual gated exponential average with staleness timeout.
// in_ch carries one transaction per pair of samples (left, right, 1/16 C)
// plus a millisecond timestamp; out_ch returns ok and both averages rounded
// to whole degrees, one result transaction per input transaction.
// The cfg_ port writes one register per cycle while cfg_we is high; write it
// only while no transaction is in flight.
// An accepted transaction is captured in the input register, worked through
// both channel datapaths into the result register and shown on out_ch from it.
// Throughput: one transaction per cycle while out_ch is not stalled; the
// per-channel multiply-accumulate on the average state is combinational.
// Reset: synchronous, active low; clears both averages and last good times
// to zero and loads the register defaults.
// Stall: while out_ch.ready is low the result holds, the input register
// keeps its transaction and in_ch.ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_gated_ema_with_timeout_assert.svh"

module dual_gated_ema_with_timeout #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int FILTER_FRAC_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire dgema_pkg::cfg_index_t              cfg_index,
  input  wire logic [dgema_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  dgema_in_if.sink                                in_ch,
  dgema_out_if.source                             out_ch
);
  import dgema_pkg::*;

  cfg_t                           cfg_r, cfg_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s1_left_r, s1_right_r;
  logic [TIME_WIDTH-1:0]          s1_now_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r;
  logic signed [OUT_WIDTH-1:0]    out_left_r, out_right_r;
  logic                           s1_adv;
  logic                           in_acc;
  logic                           fresh;
  chan_res_t                      res_left, res_right;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLAUSIBLE_MIN:    cfg_nxt.plausible_min    = $signed(cfg_wdata);
        CFG_PLAUSIBLE_MAX:    cfg_nxt.plausible_max    = $signed(cfg_wdata);
        CFG_ALPHA_Q8:         cfg_nxt.alpha_q8         = cfg_wdata[ALPHA_WIDTH-1:0];
        CFG_STALE_TIMEOUT_MS: cfg_nxt.stale_timeout_ms = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plausible_min    <= PLAUSIBLE_MIN_RST;
      cfg_r.plausible_max    <= PLAUSIBLE_MAX_RST;
      cfg_r.alpha_q8         <= ALPHA_Q8_RST;
      cfg_r.stale_timeout_ms <= STALE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: the input register moves on whenever the result slot frees.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || s1_adv;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r  <= in_ch.sample_left;
      s1_right_r <= in_ch.sample_right;
      s1_now_r   <= in_ch.now_ms;
    end
  end

  // Per-channel datapaths.
  dgema_chan #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_chan_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_adv),
    .sample (s1_left_r),
    .now_ms (s1_now_r),
    .cfg    (cfg_r),
    .res    (res_left)
  );

  dgema_chan #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_chan_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_adv),
    .sample (s1_right_r),
    .now_ms (s1_now_r),
    .cfg    (cfg_r),
    .res    (res_right)
  );

  assign fresh = res_left.fresh && res_right.fresh;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ok_r    <= fresh;
      out_left_r  <= fresh ? res_left.temp_c : '0;
      out_right_r <= fresh ? res_right.temp_c : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.temp_left_c  = out_left_r;
  assign out_ch.temp_right_c = out_right_r;

  // A stale result carries zero temperatures.
  `DGEMA_ASSERT_SAME(a_stale_zero, clk, rst_n, out_valid_r && !out_ok_r, out_left_r == '0 && out_right_r == '0)
  // A held input transaction stays put while the result is stalled.
  `DGEMA_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && out_valid_r && !out_ch.ready, s1_valid_r)
  // An accepted transaction always lands in the input register.
  `DGEMA_ASSERT_NEXT(a_in_lands, clk, rst_n, in_acc, s1_valid_r)
  // Moving the input register forward always produces a result.
  `DGEMA_ASSERT_NEXT(a_adv_result, clk, rst_n, s1_adv, out_valid_r)

endmodule

`default_nettype wire

// ===== bench/dual_gated_ema_with_timeout_tb.sv =====
`timescale 1ns / 1ps

module dual_gated_ema_with_timeout_tb;
  import dgema_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int FILT_FRAC      = 12;
  localparam int FILT_W         = SAMPLE_W + FILT_FRAC - SAMPLE_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED    = 100;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 194;

  // One expected result transaction.
  typedef struct {
    logic                        ok;
    logic signed [OUT_WIDTH-1:0] left_c;
    logic signed [OUT_WIDTH-1:0] right_c;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_index_t           cfg_index;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  dgema_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  dgema_out_if out_ch ();

  dual_gated_ema_with_timeout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Mirror of the register set and of the filter state.
  logic signed [CFG_WIDTH-1:0] lo_limit   = PLAUSIBLE_MIN_RST;
  logic signed [CFG_WIDTH-1:0] hi_limit   = PLAUSIBLE_MAX_RST;
  logic [ALPHA_WIDTH-1:0]      gain       = ALPHA_Q8_RST;
  logic [CFG_WIDTH-1:0]        timeout_ms = STALE_TIMEOUT_RST;
  logic signed [FILT_W-1:0]    avg_left   = '0;
  logic signed [FILT_W-1:0]    avg_right  = '0;
  logic [TIME_WIDTH-1:0]       good_ms_left  = '0;
  logic [TIME_WIDTH-1:0]       good_ms_right = '0;

  reading_t              expected_readings[$];
  int                    mismatch_count = 0;
  int                    quiet_cycles   = 0;
  int                    src_idle_pct   = 0;
  int                    sink_stall_pct = 0;
  logic [TIME_WIDTH-1:0] clock_ms       = '0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, changed at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // One filter update: move toward the target by gain/256, floor shift, saturate.
  function automatic logic signed [FILT_W-1:0] ema_update(
      logic signed [FILT_W-1:0] avg, logic signed [SAMPLE_W-1:0] s);
    longint target, prod, nxt, top, bottom;
    top    = (longint'(1) <<< (FILT_W - 1)) - 1;
    bottom = -(longint'(1) <<< (FILT_W - 1));
    target = longint'(s) * (longint'(1) <<< (FILT_FRAC - SAMPLE_FRAC_BITS));
    prod   = longint'(gain) * (target - longint'(avg));
    nxt    = longint'(avg) + (prod >>> 8);
    if (nxt > top) nxt = top;
    if (nxt < bottom) nxt = bottom;
    return nxt[FILT_W-1:0];
  endfunction

  // Round half away from zero to whole degrees and saturate to the output width.
  function automatic logic signed [OUT_WIDTH-1:0] to_degrees(logic signed [FILT_W-1:0] avg);
    longint mag, r;
    mag = (avg < 0) ? -longint'(avg) : longint'(avg);
    r   = (mag + (longint'(1) <<< (FILT_FRAC - 1))) >>> FILT_FRAC;
    if (avg < 0) r = -r;
    if (r > (1 <<< (OUT_WIDTH - 1)) - 1) r = (1 <<< (OUT_WIDTH - 1)) - 1;
    if (r < -(1 <<< (OUT_WIDTH - 1))) r = -(1 <<< (OUT_WIDTH - 1));
    return r[OUT_WIDTH-1:0];
  endfunction

  // Advance the mirrored state by one input transaction and return its result.
  function automatic reading_t predict_reading(logic signed [SAMPLE_W-1:0] sl,
                                               logic signed [SAMPLE_W-1:0] sr,
                                               logic [TIME_WIDTH-1:0] now);
    reading_t              res;
    logic [TIME_WIDTH-1:0] age_left, age_right;
    if (sl >= lo_limit && sl <= hi_limit) begin
      avg_left     = ema_update(avg_left, sl);
      good_ms_left = now;
    end
    if (sr >= lo_limit && sr <= hi_limit) begin
      avg_right     = ema_update(avg_right, sr);
      good_ms_right = now;
    end
    age_left   = now - good_ms_left;
    age_right  = now - good_ms_right;
    res.ok     = (age_left <= {16'd0, timeout_ms}) && (age_right <= {16'd0, timeout_ms});
    res.left_c  = res.ok ? to_degrees(avg_left) : '0;
    res.right_c = res.ok ? to_degrees(avg_right) : '0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Send one input transaction, with random sender gaps in front of it.
  task automatic send_reading(input logic signed [SAMPLE_W-1:0] sl,
                              input logic signed [SAMPLE_W-1:0] sr,
                              input logic [TIME_WIDTH-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_left  <= sl;
    in_ch.sample_right <= sr;
    in_ch.now_ms       <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_readings.push_back(predict_reading(sl, sr, now));
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Write all four registers while the block is idle and mirror them.
  task automatic set_registers(input logic signed [CFG_WIDTH-1:0] lo,
                               input logic signed [CFG_WIDTH-1:0] hi,
                               input logic [CFG_WIDTH-1:0] gain_raw,
                               input logic [CFG_WIDTH-1:0] tmo);
    wait_drained();
    write_reg(CFG_PLAUSIBLE_MIN, lo);
    write_reg(CFG_PLAUSIBLE_MAX, hi);
    write_reg(CFG_ALPHA_Q8, gain_raw);
    write_reg(CFG_STALE_TIMEOUT_MS, tmo);
    cfg_we <= 1'b0;
    lo_limit   = lo;
    hi_limit   = hi;
    gain       = gain_raw[ALPHA_WIDTH-1:0];
    timeout_ms = tmo;
    @(negedge clk);
  endtask

  // Mostly plausible samples, some anywhere, some right at the window edges.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int                          r, span;
    logic signed [SAMPLE_W-1:0]  s;
    r = $urandom_range(99);
    if (r < 70 && lo_limit <= hi_limit) begin
      span = int'(hi_limit) - int'(lo_limit);
      s    = SAMPLE_W'(int'(lo_limit) + int'($urandom_range(span)));
    end else if (r < 85) begin
      s = SAMPLE_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       s = lo_limit;
        1:       s = hi_limit;
        2:       s = SAMPLE_W'(lo_limit - 1);
        default: s = SAMPLE_W'(hi_limit + 1);
      endcase
    end
    return s;
  endfunction

  // Time mostly moves forward around the timeout, sometimes jumps or runs back.
  function automatic void advance_clock();
    int r;
    r = $urandom_range(99);
    if (r < 60)      clock_ms = clock_ms + $urandom_range(int'(timeout_ms) + 2);
    else if (r < 75) clock_ms = clock_ms + timeout_ms + 1 + $urandom_range(3);
    else if (r < 85) clock_ms = $urandom;
    else if (r < 92) clock_ms = clock_ms - $urandom_range(int'(timeout_ms));
    else             clock_ms = clock_ms + $urandom;
  endfunction

  // Window edges and out-of-range samples under the reset settings.
  task automatic test_window_edges();
    send_reading(16'sd0, 16'sd0, 32'd0);
    send_reading(-16'sd640, 16'sd3200, 32'd10);
    send_reading(-16'sd641, 16'sd3201, 32'd20);
    send_reading(-16'sd32768, 16'sd32767, 32'd30);
    send_reading(-16'sd1, 16'sd1, 32'd40);
  endtask

  // Age exactly at the timeout, one past it, and across the 32-bit wrap.
  task automatic test_timeout_edges();
    send_reading(16'sd100, 16'sd100, 32'd540);
    send_reading(-16'sd32768, 16'sd0, 32'd1040);
    send_reading(-16'sd32768, 16'sd0, 32'd1041);
    send_reading(16'sd0, 16'sd0, 32'hFFFF_FFFF);
    send_reading(16'sd0, -16'sd32768, 32'h0000_01F3);
    send_reading(16'sd0, -16'sd32768, 32'h0000_01F4);
  endtask

  // Minimum above maximum: nothing is plausible and the averages hold.
  task automatic test_empty_window();
    set_registers(16'sd100, -16'sd100, 16'd51, 16'd500);
    send_reading(16'sd0, 16'sd0, 32'd600);
    send_reading(16'sd50, 16'sd50, 32'd1300);
  endtask

  // Zero gain, unity gain, overshooting gain and the floor of a negative step.
  task automatic test_gain_extremes();
    set_registers(-16'sd32768, 16'sd32767, 16'd0, 16'd1000);
    send_reading(16'sd1600, -16'sd1600, 32'd5000);
    set_registers(-16'sd32768, 16'sd32767, 16'd256, 16'd1000);
    send_reading(16'sd1600, -16'sd1600, 32'd5001);
    set_registers(-16'sd32768, 16'sd32767, 16'd511, 16'd1000);
    send_reading(-16'sd1600, 16'sd1600, 32'd5002);
    set_registers(-16'sd32768, 16'sd32767, 16'd1, 16'd1000);
    send_reading(-16'sd1, 16'sd1, 32'd5003);
    send_reading(16'sd1, -16'sd1, 32'd5004);
  endtask

  // Averages at the state limits, outputs clipped, and half-degree rounding.
  task automatic test_output_saturation();
    set_registers(-16'sd32768, 16'sd32767, 16'd256, 16'd1000);
    send_reading(16'sd32767, -16'sd32768, 32'd6000);
    set_registers(-16'sd32768, 16'sd32767, 16'd511, 16'd1000);
    send_reading(-16'sd32768, 16'sd32767, 32'd6001);
    set_registers(-16'sd32768, 16'sd32767, 16'd256, 16'd1000);
    send_reading(16'sd8, -16'sd8, 32'd6002);
    send_reading(-16'sd24, 16'sd7, 32'd6003);
  endtask

  // One random phase: its own settings and its own idling pattern.
  task automatic test_random_phase(input int phase, input int count);
    logic signed [CFG_WIDTH-1:0] a, b, lo, hi;
    logic [CFG_WIDTH-1:0]        g, tmo;
    a = CFG_WIDTH'($urandom);
    b = CFG_WIDTH'($urandom);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (phase % PHASE_COUNT)
      0: begin lo = PLAUSIBLE_MIN_RST; hi = PLAUSIBLE_MAX_RST; g = 16'd51; tmo = 16'd500; end
      1: begin lo = -16'sd32768; hi = 16'sd32767; g = 16'd256; tmo = 16'd65535; end
      2: begin
        lo  = CFG_WIDTH'(int'($urandom_range(4000)) - 2000);
        hi  = lo + CFG_WIDTH'($urandom_range(500));
        g   = 16'd0;
        tmo = 16'd0;
      end
      3: begin g = 16'd511; tmo = CFG_WIDTH'($urandom); end
      4: begin g = CFG_WIDTH'($urandom_range(256)); tmo = CFG_WIDTH'($urandom_range(2000)); end
      5: begin
        lo  = CFG_WIDTH'($urandom_range(1000, 100));
        hi  = lo - CFG_WIDTH'($urandom_range(500, 1));
        g   = CFG_WIDTH'($urandom_range(511));
        tmo = CFG_WIDTH'($urandom_range(1000));
      end
      6: begin lo = a; hi = b; g = CFG_WIDTH'($urandom); tmo = CFG_WIDTH'($urandom); end
      default: begin g = 16'd1; tmo = CFG_WIDTH'($urandom_range(100)); end
    endcase
    // Unused upper bits of the gain write are noise the block must ignore.
    if (phase >= 4) g[CFG_WIDTH-1:ALPHA_WIDTH] = 7'($urandom);
    set_registers(lo, hi, g, tmo);
    case (phase % 4)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 66; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 66; end
      default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
    endcase
    repeat (count) begin
      advance_clock();
      send_reading(pick_sample(), pick_sample(), clock_ms);
    end
  endtask

  // Result checking and the watchdog.
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result", int'(out_ch.ok), -1);
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.ok !== want.ok)
          report_mismatch("ok", int'(out_ch.ok), int'(want.ok));
        if (out_ch.temp_left_c !== want.left_c)
          report_mismatch("temp_left_c", int'(out_ch.temp_left_c), int'(want.left_c));
        if (out_ch.temp_right_c !== want.right_c)
          report_mismatch("temp_right_c", int'(out_ch.temp_right_c), int'(want.right_c));
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[dual_gated_ema_with_timeout] ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PLAUSIBLE_MIN;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_left  = '0;
    in_ch.sample_right = '0;
    in_ch.now_ms       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_window_edges();
    test_timeout_edges();
    test_empty_window();
    test_gain_extremes();
    test_output_saturation();
    for (int p = 0; p < PHASE_COUNT; p++) test_random_phase(p, PHASE_ITEMS);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("[dual_gated_ema_with_timeout] OK");
    else
      $display("[dual_gated_ema_with_timeout] ERROR");
    $finish;
  end

endmodule
